// ===== rtl/queued_lock_manager_unit_macros.svh =====
// Assertion macros for the queued lock manager.
// Included by files that carry concurrent checks; needs aclk and aresetn in scope.
`ifndef QUEUED_LOCK_MANAGER_UNIT_MACROS_SVH
`define QUEUED_LOCK_MANAGER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define QLM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("qlm check failed");

// next-cycle implication
`define QLM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("qlm check failed");

`else

`define QLM_ASSERT_SAME(label, ante, cons)
`define QLM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/qlm_pkg.sv =====
// Shared types and constants for the queued lock manager.
// No dependencies.
`default_nettype none

package qlm_pkg;

    localparam int NUM_LOCKS  = 16;
    localparam int NUM_TASKS  = 16;

    localparam int MODE_W     = 3;
    localparam int LOCK_W     = 4;
    localparam int TASK_W     = 4;
    localparam int WAITERS_W  = 5;
    localparam int COUNT_W    = $clog2(NUM_TASKS + 1);

    localparam int LOCK_SLOTS = 2 ** LOCK_W;
    localparam int TASK_SLOTS = 2 ** TASK_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_ASSIGN   = 3'd0,
        MODE_ACQUIRE  = 3'd1,
        MODE_RELEASE  = 3'd2,
        MODE_TRY      = 3'd3,
        MODE_DEASSIGN = 3'd4
    } mode_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LOCK_W-1:0] lock_id;
        logic [TASK_W-1:0] task_id;
    } req_t;

    typedef struct packed {
        logic                 granted;
        logic                 queued;
        logic                 woken_valid;
        logic [TASK_W-1:0]    woken_task;
        logic                 was_locked;
        logic                 error;
        logic [WAITERS_W-1:0] waiters;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/qlm_in_reg.sv =====
// Input register for lock requests.
// Depends on qlm_pkg.
`default_nettype none

module qlm_in_reg import qlm_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [MODE_W-1:0] s_mode,
    input  wire logic [LOCK_W-1:0] s_lock_id,
    input  wire logic [TASK_W-1:0] s_task_id,
    input  wire logic              advance,
    output logic                   req_valid,
    output req_t                   req
);

    logic valid_reg;
    logic valid_next;
    req_t req_reg;

    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg.mode    <= s_mode;
            req_reg.lock_id <= s_lock_id;
            req_reg.task_id <= s_task_id;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

`default_nettype wire

// ===== rtl/qlm_lock_table.sv =====
// Lock state tables (held bit, queue head/tail/count per lock, per-task links)
// and the single-pass operation logic. Depends on qlm_pkg.
`default_nettype none

module qlm_lock_table import qlm_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic commit,
    input  req_t      req,
    output rsp_t      rsp
);

    logic [LOCK_SLOTS-1:0] held_reg;
    logic [TASK_W-1:0]     head_reg  [LOCK_SLOTS];
    logic [TASK_W-1:0]     tail_reg  [LOCK_SLOTS];
    logic [COUNT_W-1:0]    count_reg [LOCK_SLOTS];
    logic [TASK_W-1:0]     link_reg  [TASK_SLOTS];

    logic               cur_held;
    logic [TASK_W-1:0]  cur_head;
    logic [TASK_W-1:0]  cur_tail;
    logic [COUNT_W-1:0] cur_count;
    logic [TASK_W-1:0]  head_link;
    logic [COUNT_W-1:0] count_dec;

    logic               lock_ok;
    logic               task_ok;
    logic               head_ok;

    logic               held_next;
    logic [TASK_W-1:0]  head_next;
    logic [TASK_W-1:0]  tail_next;
    logic [COUNT_W-1:0] count_next;
    logic               link_clr_we;  // terminate the new tail's link
    logic               link_app_we;  // chain the old tail to the new task

    always_comb begin
        cur_held  = held_reg[req.lock_id];
        cur_head  = head_reg[req.lock_id];
        cur_tail  = tail_reg[req.lock_id];
        cur_count = count_reg[req.lock_id];
        head_link = link_reg[cur_head];
        count_dec = cur_count - COUNT_W'(1);

        lock_ok = 32'(req.lock_id) < NUM_LOCKS;
        task_ok = 32'(req.task_id) < NUM_TASKS;
        head_ok = 32'(cur_head) < NUM_TASKS;

        held_next   = cur_held;
        head_next   = cur_head;
        tail_next   = cur_tail;
        count_next  = cur_count;
        link_clr_we = 1'b0;
        link_app_we = 1'b0;
        rsp         = '0;

        if (lock_ok) begin
            unique case (req.mode)
                MODE_ASSIGN: begin
                    held_next  = 1'b0;
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                end
                MODE_ACQUIRE: begin
                    if (!cur_held) begin
                        held_next   = 1'b1;
                        rsp.granted = 1'b1;
                    end else if (task_ok && (cur_count < COUNT_W'(NUM_TASKS))) begin
                        link_clr_we = 1'b1;
                        if (cur_count == '0) begin
                            head_next = req.task_id;
                        end else begin
                            link_app_we = 1'b1;
                        end
                        tail_next  = req.task_id;
                        count_next = cur_count + COUNT_W'(1);
                        rsp.queued = 1'b1;
                    end
                end
                MODE_RELEASE: begin
                    if (cur_count == '0) begin
                        held_next = 1'b0;
                    end else begin
                        count_next = count_dec;
                        if (count_dec == '0) begin
                            head_next = '0;
                            tail_next = '0;
                        end else begin
                            head_next = head_ok ? head_link : '0;
                        end
                        held_next       = 1'b1;
                        rsp.woken_valid = 1'b1;
                        rsp.woken_task  = cur_head;
                    end
                end
                MODE_TRY: begin
                    if (!cur_held) begin
                        held_next   = 1'b1;
                        rsp.granted = 1'b1;
                    end else begin
                        rsp.was_locked = 1'b1;
                    end
                end
                MODE_DEASSIGN: begin
                    if (cur_held) begin
                        rsp.error = 1'b1;
                    end else begin
                        held_next  = 1'b0;
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = '0;
                    end
                end
                default: begin
                end
            endcase
            rsp.waiters = WAITERS_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
            for (int i = 0; i < LOCK_SLOTS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else if (commit && lock_ok) begin
            held_reg[req.lock_id]  <= held_next;
            head_reg[req.lock_id]  <= head_next;
            tail_reg[req.lock_id]  <= tail_next;
            count_reg[req.lock_id] <= count_next;
        end
    end

    // a task that is its own old tail keeps the self-link from the append
    always_ff @(posedge aclk) begin
        if (commit && link_clr_we && !(link_app_we && (cur_tail == req.task_id))) begin
            link_reg[req.task_id] <= '0;
        end
        if (commit && link_app_we) begin
            link_reg[cur_tail] <= req.task_id;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/qlm_out_reg.sv =====
// Result register for the lock manager's result channel.
// Depends on qlm_pkg.
`default_nettype none

module qlm_out_reg import qlm_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic load,
    input  rsp_t      rsp_in,
    input  wire logic m_ready,
    output logic      m_valid,
    output rsp_t      rsp_out
);

    logic valid_reg;
    logic valid_next;
    rsp_t rsp_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rsp_reg <= rsp_in;
        end
    end

    assign m_valid = valid_reg;
    assign rsp_out = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/queued_lock_manager_unit.sv =====
// Queued lock manager: 16 locks, FIFO wait queues linked through a per-task table.
// A result is offered after its request passes the input reg, then the result reg.
// Throughput: one request per cycle unless m_ready holds back a full result register.
// Reset (aresetn low, synchronous): clears both valid flags, all held bits and queue state;
// the per-task link table is not reset, each link is written before it is read.
`default_nettype none

`include "queued_lock_manager_unit_macros.svh"

module queued_lock_manager_unit import qlm_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [MODE_W-1:0]    s_mode,
    input  wire logic [LOCK_W-1:0]    s_lock_id,
    input  wire logic [TASK_W-1:0]    s_task_id,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_granted,
    output logic                      m_queued,
    output logic                      m_woken_valid,
    output logic [TASK_W-1:0]         m_woken_task,
    output logic                      m_was_locked,
    output logic                      m_error,
    output logic [WAITERS_W-1:0]      m_waiters
);

    logic req_valid;
    req_t req;
    logic advance;
    rsp_t rsp_comb;
    rsp_t rsp_out;
    logic [4:0] flag_vec;

    // move the pending request into the result slot when that slot frees up
    assign advance = req_valid && (!m_valid || m_ready);

    qlm_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_lock_id (s_lock_id),
        .s_task_id (s_task_id),
        .advance   (advance),
        .req_valid (req_valid),
        .req       (req)
    );

    qlm_lock_table u_lock_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (advance),
        .req     (req),
        .rsp     (rsp_comb)
    );

    qlm_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .rsp_in  (rsp_comb),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .rsp_out (rsp_out)
    );

    assign m_granted     = rsp_out.granted;
    assign m_queued      = rsp_out.queued;
    assign m_woken_valid = rsp_out.woken_valid;
    assign m_woken_task  = rsp_out.woken_task;
    assign m_was_locked  = rsp_out.was_locked;
    assign m_error       = rsp_out.error;
    assign m_waiters     = rsp_out.waiters;

    assign flag_vec = {m_granted, m_queued, m_woken_valid, m_was_locked, m_error};

    // at most one outcome flag per result beat
    `QLM_ASSERT_SAME(a_one_outcome, m_valid, $onehot0(flag_vec))
    // a queued task always leaves a nonempty queue behind
    `QLM_ASSERT_SAME(a_queued_nonempty, m_valid && m_queued, m_waiters != '0)
    // input side only stalls when both the request and result slots are full
    `QLM_ASSERT_SAME(a_stall_cause, !s_ready, req_valid && m_valid && !m_ready)
    // a stalled request stays pending
    `QLM_ASSERT_NEXT(a_pending_holds, req_valid && !advance, req_valid)

endmodule

`default_nettype wire

// ===== sim/queued_lock_manager_unit_tb.sv =====
// Self-checking testbench for queued_lock_manager_unit: directed table, then random phases.
// Depends on qlm_pkg and the RTL top; results are checked against an in-bench lock table model.
`default_nettype none

module queued_lock_manager_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qlm_pkg::*;

    localparam logic [MODE_W-1:0] MODE_BAD_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BAD_HI = 3'd7;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 405;
    localparam int TAIL_CYCLES      = 10;
    localparam int IDLE_PCT[4]      = '{0, 87, 0, 8};
    localparam int STALL_PCT[4]     = '{0, 0, 87, 8};

    localparam rsp_t RSP_NONE  = '0;
    localparam rsp_t RSP_GRANT = '{1'b1, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 5'd0};
    localparam rsp_t RSP_BUSY  = '{1'b0, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0, 5'd0};
    localparam rsp_t RSP_ERR   = '{1'b0, 1'b0, 1'b0, 4'd0, 1'b0, 1'b1, 5'd0};
    localparam rsp_t RSP_FULL  = '{1'b0, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 5'd16};

    typedef struct {
        req_t req;
        bit   typed;
        rsp_t want;
    } plan_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic [MODE_W-1:0]    s_mode    = '0;
    logic [LOCK_W-1:0]    s_lock_id = '0;
    logic [TASK_W-1:0]    s_task_id = '0;
    logic                 m_ready   = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic                 m_granted;
    logic                 m_queued;
    logic                 m_woken_valid;
    logic [TASK_W-1:0]    m_woken_task;
    logic                 m_was_locked;
    logic                 m_error;
    logic [WAITERS_W-1:0] m_waiters;

    // lock table mirror
    bit                   lk_held  [LOCK_SLOTS];
    logic [TASK_W-1:0]    q_head   [LOCK_SLOTS];
    logic [TASK_W-1:0]    q_tail   [LOCK_SLOTS];
    int unsigned          q_count  [LOCK_SLOTS];
    logic [TASK_W-1:0]    wait_link[TASK_SLOTS];

    rsp_t      lock_results[$];
    plan_row_t stim_plan[$];
    int        failures    = 0;
    int        cycle_count = 0;
    int        idle_pct    = 0;
    int        stall_pct   = 0;

    queued_lock_manager_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_lock_id     (s_lock_id),
        .s_task_id     (s_task_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_granted     (m_granted),
        .m_queued      (m_queued),
        .m_woken_valid (m_woken_valid),
        .m_woken_task  (m_woken_task),
        .m_was_locked  (m_was_locked),
        .m_error       (m_error),
        .m_waiters     (m_waiters)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void drop_lock(int l);
        lk_held[l] = 1'b0;
        q_head[l]  = '0;
        q_tail[l]  = '0;
        q_count[l] = 0;
    endfunction

    function automatic rsp_t lock_table_step(req_t r);
        rsp_t              o;
        int                l;
        logic [TASK_W-1:0] h;
        o = '0;
        l = int'(r.lock_id);
        case (r.mode)
            MODE_ASSIGN: begin
                drop_lock(l);
            end
            MODE_ACQUIRE: begin
                if (!lk_held[l]) begin
                    lk_held[l] = 1'b1;
                    o.granted  = 1'b1;
                end else if (q_count[l] < NUM_TASKS) begin
                    wait_link[r.task_id] = '0;
                    if (q_count[l] == 0) begin
                        q_head[l] = r.task_id;
                    end else begin
                        wait_link[q_tail[l]] = r.task_id;
                    end
                    q_tail[l]  = r.task_id;
                    q_count[l] = q_count[l] + 1;
                    o.queued   = 1'b1;
                end
            end
            MODE_RELEASE: begin
                if (q_count[l] == 0) begin
                    lk_held[l] = 1'b0;
                end else begin
                    // hand off straight to the head waiter
                    h          = q_head[l];
                    q_count[l] = q_count[l] - 1;
                    if (q_count[l] == 0) begin
                        q_head[l] = '0;
                        q_tail[l] = '0;
                    end else begin
                        q_head[l] = wait_link[h];
                    end
                    lk_held[l]    = 1'b1;
                    o.woken_valid = 1'b1;
                    o.woken_task  = h;
                end
            end
            MODE_TRY: begin
                if (!lk_held[l]) begin
                    lk_held[l] = 1'b1;
                    o.granted  = 1'b1;
                end else begin
                    o.was_locked = 1'b1;
                end
            end
            MODE_DEASSIGN: begin
                if (lk_held[l]) begin
                    o.error = 1'b1;
                end else begin
                    drop_lock(l);
                end
            end
            default: begin
            end
        endcase
        o.waiters = q_count[l][WAITERS_W-1:0];
        return o;
    endfunction

    // Drive one request beat and log its expected result once accepted.
    task automatic offer_request(req_t r, bit typed, rsp_t want);
        rsp_t pred;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= r.mode;
        s_lock_id <= r.lock_id;
        s_task_id <= r.task_id;
        do @(posedge aclk); while (!s_ready);
        pred = lock_table_step(r);
        lock_results.push_back(typed ? want : pred);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (lock_results.size() != 0) @(posedge aclk);
    endtask

    task automatic field_check(string name, logic [4:0] want, logic [4:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin : result_sink
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (lock_results.size() == 0) begin
                $display("%0t: result beat with no expected result pending", $time);
                failures++;
            end else begin
                want = lock_results.pop_front();
                field_check("granted", 5'(want.granted), 5'(m_granted));
                field_check("queued", 5'(want.queued), 5'(m_queued));
                field_check("woken_valid", 5'(want.woken_valid), 5'(m_woken_valid));
                field_check("woken_task", 5'(want.woken_task), 5'(m_woken_task));
                field_check("was_locked", 5'(want.was_locked), 5'(m_was_locked));
                field_check("error", 5'(want.error), 5'(m_error));
                field_check("waiters", want.waiters, m_waiters);
            end
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, lock_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        req_t r;
        int   n;
        int   pick;

        foreach (lk_held[i]) begin
            drop_lock(i);
        end
        foreach (wait_link[i]) begin
            wait_link[i] = '0;
        end

        stim_plan.push_back('{req_t'{MODE_ASSIGN, 4'd0, 4'd0}, 1'b1, RSP_NONE});
        // release of a free lock with nobody waiting
        stim_plan.push_back('{req_t'{MODE_RELEASE, 4'd3, 4'd0}, 1'b1, RSP_NONE});
        stim_plan.push_back('{req_t'{MODE_TRY, 4'd3, 4'd0}, 1'b1, RSP_GRANT});
        stim_plan.push_back('{req_t'{MODE_TRY, 4'd3, 4'd15}, 1'b1, RSP_BUSY});
        stim_plan.push_back('{req_t'{MODE_DEASSIGN, 4'd3, 4'd0}, 1'b1, RSP_ERR});
        stim_plan.push_back('{req_t'{MODE_RELEASE, 4'd3, 4'd0}, 1'b1, RSP_NONE});
        // deassign of a free lock clears it
        stim_plan.push_back('{req_t'{MODE_DEASSIGN, 4'd3, 4'd0}, 1'b1, RSP_NONE});
        stim_plan.push_back('{req_t'{MODE_BAD_HI, 4'd15, 4'd15}, 1'b1, RSP_NONE});
        stim_plan.push_back('{req_t'{MODE_ACQUIRE, 4'd15, 4'd15}, 1'b1, RSP_GRANT});
        // fill lock 15's queue with every task; this also writes every link entry
        for (int t = 0; t < NUM_TASKS; t++) begin
            stim_plan.push_back('{req_t'{MODE_ACQUIRE, 4'd15, TASK_W'(t)}, 1'b0, RSP_NONE});
        end
        stim_plan.push_back('{req_t'{MODE_ACQUIRE, 4'd15, 4'd9}, 1'b1, RSP_FULL});
        stim_plan.push_back('{req_t'{MODE_RELEASE, 4'd15, 4'd0}, 1'b0, RSP_NONE});
        stim_plan.push_back('{req_t'{MODE_ASSIGN, 4'd15, 4'd0}, 1'b1, RSP_NONE});

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_plan[i]) begin
            offer_request(stim_plan[i].req, stim_plan[i].typed, stim_plan[i].want);
        end
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = IDLE_PCT[ph];
            stall_pct = STALL_PCT[ph];
            n = 0;
            while (n < RANDOM_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    r.mode = MODE_ACQUIRE;
                end else if (pick < 68) begin
                    r.mode = MODE_RELEASE;
                end else if (pick < 78) begin
                    r.mode = MODE_TRY;
                end else if (pick < 84) begin
                    r.mode = MODE_DEASSIGN;
                end else if (pick < 90) begin
                    r.mode = MODE_ASSIGN;
                end else begin
                    r.mode = MODE_W'($urandom_range(MODE_BAD_HI, MODE_BAD_LO));
                end
                // crowd a few locks so their queues grow deep
                r.lock_id = LOCK_W'(($urandom_range(99) < 80) ? $urandom_range(3)
                                                              : $urandom_range(LOCK_SLOTS - 1));
                r.task_id = TASK_W'($urandom_range(TASK_SLOTS - 1));
                offer_request(r, 1'b0, RSP_NONE);
                n++;
            end
            // hold the sender off until the result side has caught up
            drain_results();
        end

        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
